[rtl/cstp_pkg.sv]
//------------------------------------------------------------------------------
// cstp_pkg: shared types and constants of the trajectory point unit
// Configuration record, queue entry, search stage record and CORDIC tables.
//------------------------------------------------------------------------------
package cstp_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    RegShapeMode   = 3'd0,
    RegCenterX     = 3'd1,
    RegCenterY     = 3'd2,
    RegRadius      = 3'd3,
    RegAngularRate = 3'd4,
    RegPhaseOffset = 3'd5
  } cstp_reg_e;

  typedef struct packed {
    logic               shape_mode;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [30:0] radius;
    logic signed [31:0] angular_rate;
    logic        [31:0] phase_offset;
  } cstp_cfg_t;

  // reduced angle: quadrant and signed residual in 2^-32 turn
  typedef struct packed {
    logic        [1:0]  quad;
    logic signed [31:0] resid;
  } cstp_item_t;

  // one stage of the squircle factor search
  typedef struct packed {
    logic signed [32:0] c;
    logic signed [32:0] s;
    logic        [32:0] sum;
    logic        [30:0] f;
    logic        [30:0] trial;
    logic        [33:0] pw;
    logic               bad;
  } cstp_srch_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // bits of the factor below its leading one
  localparam int unsigned FactorBits = 29;

  localparam logic signed [32:0] CordicGain = 33'sh0_26DD_3B6A;
  localparam logic        [30:0] FactorOne  = 31'h4000_0000;
  localparam logic        [33:0] F4Guard    = 34'h0_C000_0000;
  localparam logic        [66:0] F8Limit    = 67'h1 << 60;

  // arctangent of 2^-i in 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2F9;
      5'd15:   v = 32'h0000_517C;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A2F;
      5'd19:   v = 32'h0000_0517;
      5'd20:   v = 32'h0000_028B;
      5'd21:   v = 32'h0000_0145;
      5'd22:   v = 32'h0000_00A2;
      5'd23:   v = 32'h0000_0051;
      5'd24:   v = 32'h0000_0028;
      5'd25:   v = 32'h0000_0014;
      5'd26:   v = 32'h0000_000A;
      5'd27:   v = 32'h0000_0005;
      5'd28:   v = 32'h0000_0002;
      5'd29:   v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

[rtl/circle_squircle_trajectory_point_unit.sv]
//------------------------------------------------------------------------------
// circle_squircle_trajectory_point_unit: reference trajectory point generator
// Time stamp in, one circle or squircle point out, one point per cycle unless stalled.
//------------------------------------------------------------------------------
// Usage:
//   Configure through the write channel (cfg_valid_i/cfg_ready_o, index and
//   data) while no transaction is in flight; ready is always high.
//   Input transactions carry time_stamp_i and are taken when in_valid_i is high
//   and in_stall_o is low. Results appear on x_position_o, y_position_o and
//   saturated_o and are taken when out_valid_o is high and out_stall_i low.
//   Throughput is one transaction per cycle; the front end, a four-entry queue
//   and the back pipeline each stall on their own.
//   From acceptance to result valid a transaction passes the front register,
//   the queue, one CORDIC stage per rotation, four stages of quadrant fix-up
//   and powers, 116 stages of factor search (four per factor bit) and three
//   stages of scaling, placement and clipping.
//   A stalled result holds and freezes the back pipeline; the queue then fills
//   and in_stall_o rises. Reset clears the configuration registers to zero and
//   empties the pipeline and queue.
//------------------------------------------------------------------------------
module circle_squircle_trajectory_point_unit #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        time_stamp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_position_o,
  output logic signed [31:0] y_position_o,
  output logic               saturated_o
);

  cstp_pkg::cstp_cfg_t  cfg_q;
  cstp_pkg::cstp_item_t fr_item, qu_item;
  logic                 full, push, pop, avail;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cstp_pkg::cstp_reg_e'(cfg_index_i))
        cstp_pkg::RegShapeMode:   cfg_q.shape_mode   <= cfg_data_i[0];
        cstp_pkg::RegCenterX:     cfg_q.center_x     <= cfg_data_i;
        cstp_pkg::RegCenterY:     cfg_q.center_y     <= cfg_data_i;
        cstp_pkg::RegRadius:      cfg_q.radius       <= cfg_data_i[30:0];
        cstp_pkg::RegAngularRate: cfg_q.angular_rate <= cfg_data_i;
        cstp_pkg::RegPhaseOffset: cfg_q.phase_offset <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cstp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .time_stamp_i (time_stamp_i),
    .in_stall_o   (in_stall_o),
    .full_i       (full),
    .push_o       (push),
    .item_o       (fr_item)
  );

  cstp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (qu_item)
  );

  cstp_back #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .avail_i      (avail),
    .item_i       (qu_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .x_position_o (x_position_o),
    .y_position_o (y_position_o),
    .saturated_o  (saturated_o)
  );

endmodule

[rtl/cstp_front.sv]
//------------------------------------------------------------------------------
// cstp_front: angle front end
// Takes a time stamp, forms the angle and splits it into quadrant and residual.
//------------------------------------------------------------------------------
module cstp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cstp_pkg::cstp_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  input  logic [31:0]          time_stamp_i,
  output logic                 in_stall_o,
  input  logic                 full_i,
  output logic                 push_o,
  output cstp_pkg::cstp_item_t item_o
);

  logic               vld_q;
  logic [31:0]        step_q;
  logic signed [64:0] prod;
  logic               adv;
  logic [31:0]        ang;
  logic [31:0]        ang_off;

  // rate times time, keep the bits that land in the angle
  assign prod = cfg_i.angular_rate * $signed({1'b0, time_stamp_i});

  assign adv        = !vld_q || !full_i;
  assign in_stall_o = vld_q && full_i;
  assign push_o     = vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      step_q <= prod[47:16];
    end
  end

  // quadrant by rounding to the nearest quarter turn
  always_comb begin
    ang          = cfg_i.phase_offset + step_q;
    ang_off      = ang + 32'h2000_0000;
    item_o.quad  = ang_off[31:30];
    item_o.resid = $signed(ang - {ang_off[31:30], 30'b0});
  end

endmodule

[rtl/cstp_queue.sv]
//------------------------------------------------------------------------------
// cstp_queue: short queue between front end and back end
// Holds reduced angles so that each side can stall on its own.
//------------------------------------------------------------------------------
module cstp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cstp_pkg::cstp_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 avail_o,
  output cstp_pkg::cstp_item_t item_o
);

  localparam int unsigned PtrW = cstp_pkg::QueuePtrW;

  cstp_pkg::cstp_item_t mem_q [cstp_pkg::QueueDepth];
  logic [PtrW-1:0]      wr_q, wr_d;
  logic [PtrW-1:0]      rd_q, rd_d;
  logic [PtrW:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(cstp_pkg::QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // no transaction into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  // no transaction out of an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !avail_o))
    else $error("pop from empty queue");

  // fill level rises on a push without a pop
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

[rtl/cstp_cordic.sv]
//------------------------------------------------------------------------------
// cstp_cordic: pipelined rotation CORDIC
// One rotation step per stage; gives cosine and sine of the residual in Q2.30.
//------------------------------------------------------------------------------
module cstp_cordic #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  cstp_pkg::cstp_item_t item_i,
  output logic                 valid_o,
  output logic signed [32:0]   cx_o,
  output logic signed [32:0]   cy_o,
  output logic [1:0]           quad_o
);

  logic [CORDIC_STAGES-1:0] vld_q;
  logic signed [32:0]       cx_q   [CORDIC_STAGES];
  logic signed [32:0]       cy_q   [CORDIC_STAGES];
  logic signed [32:0]       z_q    [CORDIC_STAGES];
  logic [1:0]               quad_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [32:0] cx_in, cy_in, z_in;
    logic signed [32:0] cx_nx, cy_nx, z_nx;
    logic signed [32:0] ang;
    logic [1:0]         q_in;
    logic               v_in;

    if (i == 0) begin : g_first
      assign cx_in = cstp_pkg::CordicGain;
      assign cy_in = '0;
      assign z_in  = {item_i.resid[31], item_i.resid};
      assign q_in  = item_i.quad;
      assign v_in  = valid_i;
    end else begin : g_next
      assign cx_in = cx_q[i-1];
      assign cy_in = cy_q[i-1];
      assign z_in  = z_q[i-1];
      assign q_in  = quad_q[i-1];
      assign v_in  = vld_q[i-1];
    end

    assign ang = $signed({1'b0, cstp_pkg::atan_turn(5'(i))});

    // rotate towards zero residual
    always_comb begin
      if (!z_in[32]) begin
        cx_nx = cx_in - (cy_in >>> i);
        cy_nx = cy_in + (cx_in >>> i);
        z_nx  = z_in - ang;
      end else begin
        cx_nx = cx_in + (cy_in >>> i);
        cy_nx = cy_in - (cx_in >>> i);
        z_nx  = z_in + ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[i]   <= cx_nx;
        cy_q[i]   <= cy_nx;
        z_q[i]    <= z_nx;
        quad_q[i] <= q_in;
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES-1];
  assign cx_o    = cx_q[CORDIC_STAGES-1];
  assign cy_o    = cy_q[CORDIC_STAGES-1];
  assign quad_o  = quad_q[CORDIC_STAGES-1];

endmodule

[rtl/cstp_back.sv]
//------------------------------------------------------------------------------
// cstp_back: point back end
// CORDIC, quadrant fix-up, squircle factor search, scaling and placement.
//------------------------------------------------------------------------------
module cstp_back #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cstp_pkg::cstp_cfg_t  cfg_i,
  input  logic                 avail_i,
  input  cstp_pkg::cstp_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   x_position_o,
  output logic signed [31:0]   y_position_o,
  output logic                 saturated_o
);

  localparam int unsigned SrchLen = 4 * cstp_pkg::FactorBits;
  localparam logic signed [65:0] Half = 66'sh2000_0000;

  logic               en;
  logic               cd_vld;
  logic signed [32:0] cd_cx, cd_cy;
  logic [1:0]         cd_quad;

  // whole back pipeline moves unless the result is held
  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && avail_i;

  cstp_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pop_o),
    .item_i  (item_i),
    .valid_o (cd_vld),
    .cx_o    (cd_cx),
    .cy_o    (cd_cy),
    .quad_o  (cd_quad)
  );

  // quadrant fix-up and magnitudes
  logic signed [32:0] rot_c, rot_s;
  logic               rot_vld_q;
  logic signed [32:0] rot_c_q, rot_s_q;
  logic [32:0]        abs_c, abs_s;
  logic [31:0]        abs_c_q, abs_s_q;

  always_comb begin
    case (cd_quad)
      2'd0:    begin rot_c = cd_cx;  rot_s = cd_cy;  end
      2'd1:    begin rot_c = -cd_cy; rot_s = cd_cx;  end
      2'd2:    begin rot_c = -cd_cx; rot_s = -cd_cy; end
      default: begin rot_c = cd_cy;  rot_s = -cd_cx; end
    endcase
    abs_c = rot_c[32] ? -rot_c : rot_c;
    abs_s = rot_s[32] ? -rot_s : rot_s;
  end

  // eighth powers by three truncated squarings
  logic        p1_vld_q, p2_vld_q, p3_vld_q;
  logic signed [32:0] p1_c_q, p1_s_q, p2_c_q, p2_s_q, p3_c_q, p3_s_q;
  logic [31:0] c2_q, s2_q, c4_q, s4_q;
  logic [32:0] sum_q;
  logic [63:0] m1c, m1s, m2c, m2s, m3c, m3s;

  assign m1c = abs_c_q * abs_c_q;
  assign m1s = abs_s_q * abs_s_q;
  assign m2c = c2_q * c2_q;
  assign m2s = s2_q * s2_q;
  assign m3c = c4_q * c4_q;
  assign m3s = s4_q * s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_vld_q <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
    end else if (en) begin
      rot_vld_q <= cd_vld;
      p1_vld_q  <= rot_vld_q;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_c_q <= rot_c;
      rot_s_q <= rot_s;
      abs_c_q <= abs_c[31:0];
      abs_s_q <= abs_s[31:0];
      p1_c_q  <= rot_c_q;
      p1_s_q  <= rot_s_q;
      c2_q    <= m1c[61:30];
      s2_q    <= m1s[61:30];
      p2_c_q  <= p1_c_q;
      p2_s_q  <= p1_s_q;
      c4_q    <= m2c[61:30];
      s4_q    <= m2s[61:30];
      p3_c_q  <= p2_c_q;
      p3_s_q  <= p2_s_q;
      sum_q   <= {1'b0, m3c[61:30]} + {1'b0, m3s[61:30]};
    end
  end

  // factor search, one bit every four stages: f^2, f^4 with guard, f^8, test
  logic [SrchLen-1:0]   sr_vld_q;
  cstp_pkg::cstp_srch_t sr_q [SrchLen];

  for (genvar j = 0; j < SrchLen; j++) begin : g_srch
    cstp_pkg::cstp_srch_t prv, nxt;
    logic                 v_in;

    if (j == 0) begin : g_first
      always_comb begin
        prv       = '0;
        prv.c     = p3_c_q;
        prv.s     = p3_s_q;
        prv.sum   = sum_q;
        prv.f     = cstp_pkg::FactorOne;
      end
      assign v_in = p3_vld_q;
    end else begin : g_next
      assign prv  = sr_q[j-1];
      assign v_in = sr_vld_q[j-1];
    end

    if (j % 4 == 0) begin : g_trial
      logic [30:0] trial;
      logic [61:0] m;
      assign trial = prv.f | (31'(1) << (cstp_pkg::FactorBits - 1 - j / 4));
      assign m     = trial * trial;
      always_comb begin
        nxt       = prv;
        nxt.trial = trial;
        nxt.pw    = {2'b0, m[61:30]};
      end
    end else if (j % 4 == 1) begin : g_pow4
      logic [63:0] m;
      assign m = prv.pw[31:0] * prv.pw[31:0];
      always_comb begin
        nxt     = prv;
        nxt.pw  = m[63:30];
        nxt.bad = (m[63:30] > cstp_pkg::F4Guard);
      end
    end else if (j % 4 == 2) begin : g_pow8
      logic [63:0] m;
      assign m = prv.pw[31:0] * prv.pw[31:0];
      always_comb begin
        nxt    = prv;
        nxt.pw = m[63:30];
      end
    end else begin : g_test
      logic [66:0] m;
      assign m = prv.sum * prv.pw;
      always_comb begin
        nxt = prv;
        if (!prv.bad && (m <= cstp_pkg::F8Limit)) begin
          nxt.f = prv.trial;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_vld_q[j] <= 1'b0;
      end else if (en) begin
        sr_vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_q[j] <= nxt;
      end
    end
  end

  // scale by the factor in squircle mode
  cstp_pkg::cstp_srch_t sr_last;
  logic signed [64:0]   sc_c, sc_s;
  logic                 sc_vld_q;
  logic signed [33:0]   ux_q, uy_q;

  assign sr_last = sr_q[SrchLen-1];
  assign sc_c    = sr_last.c * $signed({1'b0, sr_last.f});
  assign sc_s    = sr_last.s * $signed({1'b0, sr_last.f});

  // radius times unit vector, rounded half up
  logic signed [65:0] rx, ry;
  logic               rd_vld_q;
  logic signed [35:0] tx_q, ty_q;

  assign rx = $signed({1'b0, cfg_i.radius}) * ux_q + Half;
  assign ry = $signed({1'b0, cfg_i.radius}) * uy_q + Half;

  // add centre and clip to 32 bits
  logic signed [37:0] vx, vy;
  logic               hix, lox, hiy, loy;
  logic signed [31:0] x_d, y_d;

  assign vx = {{6{cfg_i.center_x[31]}}, cfg_i.center_x} + {{2{tx_q[35]}}, tx_q};
  assign vy = {{6{cfg_i.center_y[31]}}, cfg_i.center_y} + {{2{ty_q[35]}}, ty_q};

  always_comb begin
    hix = !vx[37] && (vx[36:31] != '0);
    lox = vx[37] && (vx[36:31] != '1);
    hiy = !vy[37] && (vy[36:31] != '0);
    loy = vy[37] && (vy[36:31] != '1);
    x_d = hix ? 32'sh7FFF_FFFF : (lox ? 32'sh8000_0000 : vx[31:0]);
    y_d = hiy ? 32'sh7FFF_FFFF : (loy ? 32'sh8000_0000 : vy[31:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      sc_vld_q    <= sr_vld_q[SrchLen-1];
      rd_vld_q    <= sc_vld_q;
      out_valid_o <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q         <= cfg_i.shape_mode ? sc_c[63:30] : {sr_last.c[32], sr_last.c};
      uy_q         <= cfg_i.shape_mode ? sc_s[63:30] : {sr_last.s[32], sr_last.s};
      tx_q         <= rx[65:30];
      ty_q         <= ry[65:30];
      x_position_o <= x_d;
      y_position_o <= y_d;
      saturated_o  <= hix || lox || hiy || loy;
    end
  end

endmodule

[tb/sv/circle_squircle_trajectory_point_unit_tb.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// circle_squircle_trajectory_point_unit_tb: self-checking bench of the point unit
// Drives time stamps under several path settings, predicts each point with a
// behavioural CORDIC and squircle factor search, and checks every result.
//------------------------------------------------------------------------------
module circle_squircle_trajectory_point_unit_tb;

  localparam int unsigned Stages   = 24;
  localparam int unsigned Latency  = Stages + 124;
  localparam longint      CycleCap = 600000;

  typedef struct {
    logic signed [31:0] xp;
    logic signed [31:0] yp;
    logic               sat;
  } point_t;

  // path settings mirrored from the register writes
  logic               path_squircle;
  logic signed [31:0] path_cx;
  logic signed [31:0] path_cy;
  logic        [30:0] path_radius;
  logic signed [31:0] path_rate;
  logic        [31:0] path_phase;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned sq30(longint unsigned v);
    return (v * v) >> 30;
  endfunction

  function automatic bit factor_ok(longint unsigned f, longint unsigned total);
    longint unsigned f4;
    longint unsigned f8;
    f4 = sq30(sq30(f));
    if (f4 > (64'd3 << 30)) return 1'b0;
    f8 = sq30(f4);
    return (total * f8) <= (64'd1 << 60);
  endfunction

  function automatic longint clip32(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // predicted point for one time stamp under the current path settings
  function automatic point_t trajectory_point(logic [31:0] ts);
    longint          prod;
    logic     [31:0] ang;
    logic     [31:0] resid;
    logic     [1:0]  quad;
    longint          z, cx, cy, dx, dy, c, s, a;
    longint unsigned total, f, trial;
    bit              hit;
    point_t          p;
    prod  = longint'(path_rate) * longint'({32'd0, ts});
    ang   = path_phase + 32'(prod >>> 16);
    quad  = 2'((ang + 32'h2000_0000) >> 30);
    resid = ang - ({30'd0, quad} << 30);
    z     = longint'(signed'(resid));
    cx    = 64'h26DD3B6A;
    cy    = 0;
    for (int i = 0; i < Stages; i++) begin
      dx = floor_shr(cy, i);
      dy = floor_shr(cx, i);
      a  = longint'(cstp_pkg::atan_turn(5'(i)));
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= a;
      end else begin
        cx += dx; cy -= dy; z += a;
      end
    end
    case (quad)
      2'd0:    begin c = cx;  s = cy;  end
      2'd1:    begin c = -cy; s = cx;  end
      2'd2:    begin c = -cx; s = -cy; end
      default: begin c = cy;  s = -cx; end
    endcase
    if (path_squircle) begin
      total = sq30(sq30(sq30((c < 0) ? -c : c))) + sq30(sq30(sq30((s < 0) ? -s : s)));
      f = 64'd1 << 30;
      for (int b = 28; b >= 0; b--) begin
        trial = f | (64'd1 << b);
        if (factor_ok(trial, total)) f = trial;
      end
      c = floor_shr(c * longint'(f), 30);
      s = floor_shr(s * longint'(f), 30);
    end
    hit   = 1'b0;
    p.xp  = 32'(clip32(longint'(path_cx)
            + floor_shr(longint'({33'd0, path_radius}) * c + (64'sd1 << 29), 30), hit));
    p.yp  = 32'(clip32(longint'(path_cy)
            + floor_shr(longint'({33'd0, path_radius}) * s + (64'sd1 << 29), 30), hit));
    p.sat = hit;
    return p;
  endfunction

  // scoreboard of outstanding points
  class point_board;
    point_t pending[$];
    int     errors;
    int     checked;

    function void note_stamp(logic [31:0] ts);
      pending.push_back(trajectory_point(ts));
    endfunction

    function void check_point(logic signed [31:0] xp, logic signed [31:0] yp, logic sat);
      point_t e;
      if (pending.size() == 0) begin
        $error("unexpected point x=%0d y=%0d", xp, yp);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (xp !== e.xp) begin
        $error("x_position expected %0d actual %0d", e.xp, xp);
        errors++;
      end
      if (yp !== e.yp) begin
        $error("y_position expected %0d actual %0d", e.yp, yp);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %0d actual %0d", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [31:0]        time_stamp_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic signed [31:0] x_position_o;
  logic signed [31:0] y_position_o;
  logic               saturated_o;

  point_board board = new();
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;
  bit         hold_off = 1'b0;
  longint     cycles = 0;
  int         stamps = 0;

  circle_squircle_trajectory_point_unit #(.CORDIC_STAGES(Stages)) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_point(x_position_o, y_position_o, saturated_o);
    out_stall_i <= hold_off || (!recv_calm && ($urandom_range(99) < 34));
  end

  // receiver hold-off counted in its own process
  initial begin
    wait (stamps >= 400);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(cstp_pkg::cstp_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      cstp_pkg::RegShapeMode:   path_squircle = val[0];
      cstp_pkg::RegCenterX:     path_cx       = val;
      cstp_pkg::RegCenterY:     path_cy       = val;
      cstp_pkg::RegRadius:      path_radius   = val[30:0];
      cstp_pkg::RegAngularRate: path_rate     = val;
      default:                  path_phase    = val;
    endcase
  endtask

  task automatic set_path(logic mode, logic [31:0] cx, logic [31:0] cy, logic [31:0] rad,
                          logic [31:0] rate, logic [31:0] phase);
    write_reg(cstp_pkg::RegShapeMode, {31'd0, mode});
    write_reg(cstp_pkg::RegCenterX, cx);
    write_reg(cstp_pkg::RegCenterY, cy);
    write_reg(cstp_pkg::RegRadius, rad);
    write_reg(cstp_pkg::RegAngularRate, rate);
    write_reg(cstp_pkg::RegPhaseOffset, phase);
  endtask

  // one stamp, with a random gap first unless send_calm is set
  task automatic send_stamp(logic [31:0] ts);
    if (!send_calm)
      while ($urandom_range(99) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i   <= 1'b1;
    time_stamp_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    board.note_stamp(ts);
    stamps++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  logic [31:0] special_ts[8] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000,
                                 32'h0000_4000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_AAAA};

  initial begin
    path_squircle = 0; path_cx = 0; path_cy = 0;
    path_radius = 0; path_rate = 0; path_phase = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, then extremes: large radius clips, quarter turns
    foreach (special_ts[i]) send_stamp(special_ts[i]);
    drain();
    set_path(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0);
    foreach (special_ts[i]) send_stamp(special_ts[i]);
    drain();
    set_path(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    foreach (special_ts[i]) send_stamp(special_ts[i]);
    drain();

    // random phases, each under its own path
    for (int ph = 0; ph < 8; ph++) begin
      set_path(1'($urandom), (ph % 3 == 0) ? $urandom : $urandom_range(32'h0010_0000),
               (ph % 3 == 0) ? $urandom : $urandom_range(32'h0010_0000),
               (ph == 4) ? 32'h7FFF_FFFF : $urandom, $urandom, $urandom);
      send_calm = (ph == 2);
      recv_calm = (ph == 2);
      for (int n = 0; n < 140; n++)
        send_stamp((n % 4 == 0) ? $urandom_range(32'h0004_0000) : $urandom);
      drain();
    end

    $display("covered %0d stamps over circle and squircle paths, clipping and quadrants",
             stamps);
    $display("%0d points checked, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
